### rtl/tccw_pkg.sv
`default_nettype none
package tccw_pkg;

	localparam int ROWS_DEF = 25;
	localparam int COLS_DEF = 80;

	localparam logic [7:0] BLANK_CHAR = 8'h20;
	localparam logic [7:0] BS_CHAR    = 8'h08;
	localparam logic [7:0] NL_CHAR    = 8'h0A;
	localparam logic [7:0] ATTR_RESET = 8'h0F;

	localparam int REQ_W  = 3;
	localparam int LOC_W  = 12;
	localparam int CURP_W = 11;
	localparam int CELL_W = 16;

	localparam logic [REQ_W-1:0] REQ_PUT    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_WRITE  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_SETCUR = 3'd3;
	localparam logic [REQ_W-1:0] REQ_READ   = 3'd4;

	// packed so that req_type sits in the low bits
	typedef struct packed {
		logic [LOC_W-1:0] cursor_location;
		logic [6:0]       column_index;
		logic [5:0]       row_index;
		logic [7:0]       cell_color;
		logic [7:0]       char_code;
		logic [REQ_W-1:0] req_type;
	} tccw_req_t;

	typedef struct packed {
		logic              cell_in_range;
		logic [CELL_W-1:0] read_cell;
		logic [CURP_W-1:0] cursor_position;
	} tccw_res_t;

	localparam int REQ_BITS = $bits(tccw_req_t);
	localparam int RES_BITS = $bits(tccw_res_t);

endpackage
`default_nettype wire

### rtl/tccw_ram.sv
`default_nettype none
module tccw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### rtl/tccw_ctrl.sv
`default_nettype none
module tccw_ctrl
	import tccw_pkg::*;
#(
	parameter int ROWS = ROWS_DEF,
	parameter int COLS = COLS_DEF,
	localparam int CELLS = ROWS * COLS,
	localparam int AW = $clog2(CELLS)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire tccw_req_t         req,
	input  wire logic [7:0]        attr,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output tccw_res_t              res,
	output logic                   ram_we,
	output logic [AW-1:0]          ram_waddr,
	output logic [CELL_W-1:0]      ram_wdata,
	output logic                   ram_re,
	output logic [AW-1:0]          ram_raddr,
	input  wire logic [CELL_W-1:0] ram_rdata
);

	localparam int CW  = $clog2(CELLS + 1);
	localparam int CLW = $clog2(COLS);
	localparam int LW  = (CW > LOC_W) ? CW : LOC_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_RESP   = 3'd1;
	localparam logic [2:0] ST_SCROLL = 3'd2;
	localparam logic [2:0] ST_SFIN   = 3'd3;
	localparam logic [2:0] ST_PUTC   = 3'd4;
	localparam logic [2:0] ST_CLEAR  = 3'd5;
	localparam logic [2:0] ST_DIV    = 3'd6;

	logic [2:0]     state_q, state_d;
	logic [CW-1:0]  cursor_q, cursor_d;
	logic [CLW-1:0] col_q, col_d;
	logic [AW-1:0]  cnt_q, cnt_d;
	logic [7:0]     char_q, char_d;
	logic [CW-1:0]  rem_q, rem_d;
	logic           hit_q, hit_d;
	logic           rdsel_q, rdsel_d;

	// scroll write stage
	logic           v_s1, v_d;
	logic           blank_s1, blank_d;
	logic [AW-1:0]  addr_s1;

	logic [CELL_W-1:0] blank_cell;
	logic              in_range;
	logic [AW-1:0]     cell_addr;
	logic [LW-1:0]     loc_ext;
	logic [CW-1:0]     loc_sat;

	logic [7:0]        put_ch;
	logic              put_we;
	logic [AW-1:0]     put_addr;
	logic [CELL_W-1:0] put_data;
	logic [CW-1:0]     put_cursor;
	logic [CLW-1:0]    put_col;
	logic [CLW-1:0]    col_inc, col_dec;

	assign blank_cell = {attr, BLANK_CHAR};
	assign in_range   = ({1'b0, req.row_index} < 7'(ROWS)) &&
		({1'b0, req.column_index} < 8'(COLS));
	assign cell_addr  = AW'(32'(req.row_index) * COLS + 32'(req.column_index));
	assign loc_ext    = LW'(req.cursor_location);
	assign loc_sat    = (loc_ext > LW'(CELLS)) ? CW'(CELLS) : CW'(loc_ext);

	assign col_inc = (col_q == CLW'(COLS - 1)) ? '0 : col_q + 1'b1;
	assign col_dec = (col_q == '0) ? CLW'(COLS - 1) : col_q - 1'b1;
	assign put_ch  = (state_q == ST_IDLE) ? req.char_code : char_q;

	always_comb begin
		put_we     = 1'b0;
		put_addr   = cursor_q[AW-1:0];
		put_data   = {attr, put_ch};
		put_cursor = cursor_q;
		put_col    = col_q;
		priority if (put_ch == BS_CHAR) begin
			if (cursor_q != '0) begin
				put_we     = 1'b1;
				put_addr   = AW'(cursor_q - 1'b1);
				put_data   = blank_cell;
				put_cursor = cursor_q - 1'b1;
				put_col    = col_dec;
			end
		end else if (put_ch == NL_CHAR) begin
			put_cursor = cursor_q + CW'(COLS) - CW'(col_q);
			put_col    = '0;
		end else begin
			put_we     = 1'b1;
			put_cursor = cursor_q + 1'b1;
			put_col    = col_inc;
		end
	end

	always_comb begin
		state_d   = state_q;
		cursor_d  = cursor_q;
		col_d     = col_q;
		cnt_d     = cnt_q;
		char_d    = char_q;
		rem_d     = rem_q;
		hit_d     = hit_q;
		rdsel_d   = rdsel_q;
		v_d       = 1'b0;
		blank_d   = 1'b0;
		req_ready = (state_q == ST_IDLE);
		res_valid = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = put_addr;
		ram_wdata = put_data;
		ram_re    = 1'b0;
		ram_raddr = cell_addr;
		if (v_s1) begin
			ram_we    = 1'b1;
			ram_waddr = addr_s1;
			ram_wdata = blank_s1 ? blank_cell : ram_rdata;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					hit_d   = 1'b0;
					rdsel_d = 1'b0;
					char_d  = req.char_code;
					state_d = ST_RESP;
					unique case (req.req_type)
						REQ_PUT: begin
							if (cursor_q >= CW'(CELLS)) begin
								cnt_d   = '0;
								state_d = ST_SCROLL;
							end else begin
								ram_we   = put_we;
								cursor_d = put_cursor;
								col_d    = put_col;
							end
						end
						REQ_WRITE: begin
							if (in_range) begin
								ram_we    = 1'b1;
								ram_waddr = cell_addr;
								ram_wdata = {req.cell_color, req.char_code};
								hit_d     = 1'b1;
							end
						end
						REQ_CLEAR: begin
							cnt_d   = '0;
							state_d = ST_CLEAR;
						end
						REQ_SETCUR: begin
							cursor_d = loc_sat;
							rem_d    = loc_sat;
							state_d  = ST_DIV;
						end
						REQ_READ: begin
							if (in_range) begin
								ram_re  = 1'b1;
								hit_d   = 1'b1;
								rdsel_d = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_SCROLL: begin
				v_d     = 1'b1;
				blank_d = (cnt_q >= AW'(CELLS - COLS));
				if (!blank_d) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(32'(cnt_q) + COLS);
				end
				if (cnt_q == AW'(CELLS - 1)) begin
					state_d = ST_SFIN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_SFIN: begin
				cursor_d = CW'(CELLS - COLS);
				col_d    = '0;
				state_d  = ST_PUTC;
			end
			ST_PUTC: begin
				ram_we   = put_we;
				cursor_d = put_cursor;
				col_d    = put_col;
				state_d  = ST_RESP;
			end
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q;
				ram_wdata = blank_cell;
				cursor_d  = '0;
				col_d     = '0;
				if (cnt_q == AW'(CELLS - 1)) begin
					state_d = ST_RESP;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_DIV: begin
				if (rem_q >= CW'(COLS)) begin
					rem_d = rem_q - CW'(COLS);
				end else begin
					col_d   = CLW'(rem_q);
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cursor_q <= '0;
			col_q    <= '0;
			cnt_q    <= '0;
			hit_q    <= 1'b0;
			rdsel_q  <= 1'b0;
			v_s1     <= 1'b0;
		end else begin
			state_q  <= state_d;
			cursor_q <= cursor_d;
			col_q    <= col_d;
			cnt_q    <= cnt_d;
			hit_q    <= hit_d;
			rdsel_q  <= rdsel_d;
			v_s1     <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		char_q   <= char_d;
		rem_q    <= rem_d;
		blank_s1 <= blank_d;
		addr_s1  <= cnt_q;
	end

	assign res.cursor_position = CURP_W'(cursor_q);
	assign res.read_cell       = rdsel_q ? ram_rdata : '0;
	assign res.cell_in_range   = hit_q;

	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= CW'(CELLS))
		else $error("cursor beyond screen");

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> {1'b0, col_q} < (CLW + 1)'(COLS))
		else $error("column tracker out of range");

	a_waddr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> {1'b0, ram_waddr} < (AW + 1)'(CELLS))
		else $error("cell write out of range");

	a_rw_apart: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && ram_re |-> ram_waddr != ram_raddr)
		else $error("read and write to one cell in one cycle");

	a_scroll_tail: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCROLL && cnt_q == AW'(CELLS - 1)
		|=> v_s1 && blank_s1 && addr_s1 == AW'(CELLS - 1) && state_q == ST_SFIN)
		else $error("scroll did not end on last blank cell");

endmodule
`default_nettype wire

### rtl/text_console_cell_writer.sv
// channel  dir  tdata fields (low bit up)                                     extra
// s_axis   in   req_type[2:0] char_code[10:3] cell_color[18:11]             -
//               row_index[24:19] column_index[31:25] cursor_location[43:32]
// m_axis   out  cursor_position[10:0] read_cell[26:11] cell_in_range[27]     -
// cfg      in   cfg_wdata = text_attribute, written when cfg_we              -
//
// Put char, write cell, read cell, unknown: at most one cell RAM access per beat (cell RAM port).
// Put char with cursor past the screen: rows move up through the RAM, last row blanked, then the char is put.
// Clear: every cell is written blank and the cursor returns to zero.
// Set cursor: location saturates at ROWS*COLS; the column is found by repeated subtraction of COLS.
// Reset zeroes the cursor and sets the attribute to ATTR_RESET; cell RAM is undefined until written, no clearing pass.
// One beat in flight; a result waiting in the output register holds the next one at its end.
`default_nettype none
module text_console_cell_writer
	import tccw_pkg::*;
#(
	parameter int ROWS = ROWS_DEF,
	parameter int COLS = COLS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// req_type, char_code, cell_color, row_index, column_index, cursor_location
	input  wire logic [47:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// cursor_position, read_cell, cell_in_range
	output logic [31:0]      m_tdata,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata
);

	localparam int CELLS = ROWS * COLS;
	localparam int AW    = $clog2(CELLS);

	tccw_req_t         req;
	tccw_res_t         res;
	tccw_res_t         res_q;
	logic              res_valid;
	logic              res_ready;
	logic [7:0]        attr_q;
	logic              m_tvalid_q;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	assign req       = tccw_req_t'(s_tdata[REQ_BITS-1:0]);
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q     <= ATTR_RESET;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				attr_q <= cfg_wdata;
			end
			if (res_valid && res_ready) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(32 - RES_BITS)'(0), res_q};

	tccw_ctrl #(
		.ROWS(ROWS),
		.COLS(COLS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req       (req),
		.attr      (attr_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	tccw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
`default_nettype wire
